@@ design/lkvc_pkg.sv @@
// ----------------------------------------------------------------------------
// lkvc_pkg: shared types and constants of the LRU key-value cache
// Field widths, request codes, sequencer states and scan status flags.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	localparam int KEY_W     = 32;
	localparam int VAL_W     = 32;
	localparam int CFG_W     = 5;
	localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

	// request kinds
	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	// value returned when no stored value is read
	localparam logic signed [VAL_W-1:0] MISS_VALUE = -32'sd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_UPDATE
	} state_t;

	// what the sweep over the entries found
	typedef struct packed {
		logic done;        // last entry compared this cycle
		logic hit;         // key present in a valid entry
		logic free_found;  // at least one invalid entry
		logic lru_found;   // valid entry with the oldest rank
	} scan_flags_t;

endpackage

@@ design/lkvc_if.sv @@
// ----------------------------------------------------------------------------
// lkvc_if: request and response channels of the LRU key-value cache
// Valid/ready channels; a beat moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface lkvc_req_if;
	logic                                valid;
	logic                                ready;
	logic                                op;
	logic [lkvc_pkg::KEY_W-1:0]          req_key;
	logic signed [lkvc_pkg::VAL_W-1:0]   write_value;

	modport source (output valid, op, req_key, write_value, input ready);
	modport sink   (input valid, op, req_key, write_value, output ready);
endinterface

interface lkvc_rsp_if;
	logic                                valid;
	logic                                ready;
	logic                                hit;
	logic signed [lkvc_pkg::VAL_W-1:0]   read_value;
	logic                                evicted;
	logic [lkvc_pkg::KEY_W-1:0]          evicted_key;

	modport source (output valid, hit, read_value, evicted, evicted_key, input ready);
	modport sink   (input valid, hit, read_value, evicted, evicted_key, output ready);
endinterface

@@ design/lkvc_ram.sv @@
// ----------------------------------------------------------------------------
// lkvc_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lkvc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/lkvc_scan.sv @@
// ----------------------------------------------------------------------------
// lkvc_scan: entry sweep with one shared key comparator
// Walks the entry RAM one address a cycle and records the hit slot, the
// first free slot and the least recent slot.
// ----------------------------------------------------------------------------
module lkvc_scan #(
	parameter int ENTRIES = 16
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  logic [lkvc_pkg::KEY_W-1:0]                   req_key,
	input  logic [$clog2(ENTRIES+1)-1:0]                 occ,
	// entry RAM read side
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] rd_addr,
	input  logic [lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:0]   rd_data,
	// per-entry state of the entry under compare
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] cmp_idx,
	input  logic                                         cmp_valid,
	input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] cmp_rank,
	// results
	output lkvc_pkg::scan_flags_t                        flags,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_slot,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_rank,
	output logic [lkvc_pkg::VAL_W-1:0]                   hit_value,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_slot,
	output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] lru_slot,
	output logic [lkvc_pkg::KEY_W-1:0]                   lru_key
);

	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW = $clog2(ENTRIES + 1);
	localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

	logic          busy_q;
	logic [IW-1:0] rd_idx_q;
	logic          cmp_vld_s1;
	logic [IW-1:0] cmp_idx_s1;
	logic          hit_q;
	logic          free_q;
	logic          lru_q;
	logic [lkvc_pkg::KEY_W-1:0] ent_key;
	logic [lkvc_pkg::VAL_W-1:0] ent_value;
	logic          key_match;
	logic          lru_match;

	assign ent_key   = rd_data[lkvc_pkg::KEY_W+lkvc_pkg::VAL_W-1:lkvc_pkg::VAL_W];
	assign ent_value = rd_data[lkvc_pkg::VAL_W-1:0];
	assign key_match = cmp_valid && (ent_key == req_key);
	assign lru_match = cmp_valid && (CW'(cmp_rank) == (occ - CW'(1)));

	assign rd_addr = rd_idx_q;
	assign cmp_idx = cmp_idx_s1;

	// address counter and compare stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			rd_idx_q   <= '0;
			cmp_vld_s1 <= 1'b0;
			cmp_idx_s1 <= '0;
		end else begin
			cmp_vld_s1 <= busy_q;
			cmp_idx_s1 <= rd_idx_q;
			if (start) begin
				busy_q   <= 1'b1;
				rd_idx_q <= '0;
			end else if (busy_q) begin
				rd_idx_q <= rd_idx_q + IW'(1);
				if (rd_idx_q == LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// capture the first qualifying entry of each kind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (start) begin
			hit_q  <= 1'b0;
			free_q <= 1'b0;
			lru_q  <= 1'b0;
		end else if (cmp_vld_s1) begin
			if (key_match && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (!cmp_valid && !free_q) begin
				free_q <= 1'b1;
			end
			if (lru_match && !lru_q) begin
				lru_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmp_vld_s1) begin
			if (key_match && !hit_q) begin
				hit_slot  <= cmp_idx_s1;
				hit_rank  <= cmp_rank;
				hit_value <= ent_value;
			end
			if (!cmp_valid && !free_q) begin
				free_slot <= cmp_idx_s1;
			end
			if (lru_match && !lru_q) begin
				lru_slot <= cmp_idx_s1;
				lru_key  <= ent_key;
			end
		end
	end

	assign flags.done       = cmp_vld_s1 && (cmp_idx_s1 == LAST);
	assign flags.hit        = hit_q;
	assign flags.free_found = free_q;
	assign flags.lru_found  = lru_q;

endmodule

@@ design/lru_key_value_cache.sv @@
// ----------------------------------------------------------------------------
// lru_key_value_cache: fully associative key-value store with LRU replacement
// Gets and puts on 32-bit keys; a put that misses on a full cache evicts the least
// recent entry and reports its key.
// ----------------------------------------------------------------------------
// Each request passes through accept, the registered RAM read, one compare per entry
//   on the single key comparator and the commit; the next request is accepted only
//   after the commit, which waits while an untaken response is held.
// A response waiting in the output register does not block the next request.
// Reset clears all valid bits, ranks and the occupancy count at once and
//   sets the capacity register to 16; key and value storage is not cleared.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int ENTRIES = 16
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [lkvc_pkg::CFG_W-1:0]  cfg_wdata,
	lkvc_req_if.sink                    req,
	lkvc_rsp_if.source                  rsp
);

	localparam int IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int WIDE = (CW > lkvc_pkg::CFG_W) ? CW : lkvc_pkg::CFG_W;
	localparam int DW   = lkvc_pkg::KEY_W + lkvc_pkg::VAL_W;

	// configuration and cache state
	logic [lkvc_pkg::CFG_W-1:0] cap_q;
	logic [ENTRIES-1:0]         valid_q;
	logic [IW-1:0]              rank_q [ENTRIES];
	logic [CW-1:0]              occ_q;

	// request held for the whole sweep
	logic                              op_q;
	logic [lkvc_pkg::KEY_W-1:0]        key_q;
	logic [lkvc_pkg::VAL_W-1:0]        wval_q;

	// response register
	logic                              rsp_valid_q;
	logic                              rsp_hit_q;
	logic [lkvc_pkg::VAL_W-1:0]        rsp_rval_q;
	logic                              rsp_ev_q;
	logic [lkvc_pkg::KEY_W-1:0]        rsp_evk_q;

	lkvc_pkg::state_t state_q, state_d;

	logic req_beat;
	logic commit;

	// scan interface
	logic [IW-1:0]  rd_addr;
	logic [DW-1:0]  rd_data;
	logic [IW-1:0]  cmp_idx;
	lkvc_pkg::scan_flags_t flags;
	logic [IW-1:0]  hit_slot;
	logic [IW-1:0]  hit_rank;
	logic [lkvc_pkg::VAL_W-1:0] hit_value;
	logic [IW-1:0]  free_slot;
	logic [IW-1:0]  lru_slot;
	logic [lkvc_pkg::KEY_W-1:0] lru_key;

	// commit decisions
	logic [WIDE-1:0] cap_eff;
	logic           do_fill;
	logic           do_evict;
	logic           self_evict;
	logic           do_promote;
	logic           age_all;
	logic [IW-1:0]  slot;
	logic [IW-1:0]  old_rank;
	logic           ram_we;
	logic [lkvc_pkg::VAL_W-1:0] nxt_rval;
	logic           nxt_ev;
	logic [lkvc_pkg::KEY_W-1:0] nxt_evk;

	assign req_beat = req.valid && req.ready;

	// ---------------------------------------------------------------- sequencer
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lkvc_pkg::ST_IDLE: begin
				if (req_beat) begin
					state_d = lkvc_pkg::ST_SCAN;
				end
			end
			lkvc_pkg::ST_SCAN: begin
				if (flags.done) begin
					state_d = lkvc_pkg::ST_UPDATE;
				end
			end
			lkvc_pkg::ST_UPDATE: begin
				if (commit) begin
					state_d = lkvc_pkg::ST_IDLE;
				end
			end
			default: state_d = lkvc_pkg::ST_IDLE;
		endcase
	end

	// Accept only in idle; commit once the response register is free or drains.
	always_comb begin
		req.ready = 1'b0;
		commit    = 1'b0;
		unique case (state_q)
			lkvc_pkg::ST_IDLE:   req.ready = 1'b1;
			lkvc_pkg::ST_SCAN:   ;
			lkvc_pkg::ST_UPDATE: commit = !rsp_valid_q || rsp.ready;
			default:             ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkvc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Hold the request beat for the duration of the sweep.
	always_ff @(posedge clk) begin
		if (req_beat) begin
			op_q   <= req.op;
			key_q  <= req.req_key;
			wval_q <= req.write_value;
		end
	end

	// ---------------------------------------------------------------- storage
	lkvc_ram #(
		.WIDTH (DW),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot),
		.wdata ({key_q, wval_q}),
		.raddr (rd_addr),
		.rdata (rd_data)
	);

	lkvc_scan #(
		.ENTRIES (ENTRIES)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_beat),
		.req_key   (key_q),
		.occ       (occ_q),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.cmp_idx   (cmp_idx),
		.cmp_valid (valid_q[cmp_idx]),
		.cmp_rank  (rank_q[cmp_idx]),
		.flags     (flags),
		.hit_slot  (hit_slot),
		.hit_rank  (hit_rank),
		.hit_value (hit_value),
		.free_slot (free_slot),
		.lru_slot  (lru_slot),
		.lru_key   (lru_key)
	);

	// ---------------------------------------------------------------- decisions
	// Clamp the capacity register to the number of slots.
	assign cap_eff = (WIDE'(cap_q) < WIDE'(ENTRIES)) ? WIDE'(cap_q) : WIDE'(ENTRIES);

	always_comb begin
		do_fill    = 1'b0;
		do_evict   = 1'b0;
		self_evict = 1'b0;
		if (!flags.hit && op_q == lkvc_pkg::OP_PUT) begin
			priority if (WIDE'(occ_q) < cap_eff) begin
				do_fill = flags.free_found;
			end else if (occ_q == '0) begin
				// zero capacity and empty: the put evicts itself
				self_evict = 1'b1;
			end else begin
				do_evict = flags.lru_found;
			end
		end
	end

	always_comb begin
		slot       = hit_slot;
		old_rank   = hit_rank;
		age_all    = 1'b0;
		do_promote = flags.hit;
		ram_we     = 1'b0;
		nxt_rval   = lkvc_pkg::MISS_VALUE;
		nxt_ev     = 1'b0;
		nxt_evk    = '0;
		if (flags.hit) begin
			ram_we = commit && (op_q == lkvc_pkg::OP_PUT);
			if (op_q == lkvc_pkg::OP_GET) begin
				nxt_rval = hit_value;
			end
		end else if (do_fill) begin
			slot       = free_slot;
			age_all    = 1'b1;
			do_promote = 1'b1;
			ram_we     = commit;
		end else if (do_evict) begin
			slot       = lru_slot;
			old_rank   = IW'(occ_q - CW'(1));
			do_promote = 1'b1;
			ram_we     = commit;
			nxt_ev     = 1'b1;
			nxt_evk    = lru_key;
		end else if (self_evict) begin
			nxt_ev  = 1'b1;
			nxt_evk = key_q;
		end
	end

	// ---------------------------------------------------------------- commit
	// Promote the slot to rank zero; age newer valid entries, or all on a fill.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			for (int i = 0; i < ENTRIES; i++) begin
				rank_q[i] <= '0;
			end
		end else if (commit) begin
			if (do_fill) begin
				valid_q[slot] <= 1'b1;
				occ_q         <= occ_q + CW'(1);
			end
			if (do_promote) begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (IW'(i) == slot) begin
						rank_q[i] <= '0;
					end else if (valid_q[i] && (age_all || rank_q[i] < old_rank)) begin
						rank_q[i] <= rank_q[i] + IW'(1);
					end
				end
			end
		end
	end

	// Load the response register on commit; drop it once the beat is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_hit_q  <= flags.hit;
			rsp_rval_q <= nxt_rval;
			rsp_ev_q   <= nxt_ev;
			rsp_evk_q  <= nxt_evk;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.hit         = rsp_hit_q;
	assign rsp.read_value  = rsp_rval_q;
	assign rsp.evicted     = rsp_ev_q;
	assign rsp.evicted_key = rsp_evk_q;

endmodule
